@@ src/exl_pkg.sv @@
`default_nettype none

package exl_pkg;

    localparam int LINE_BYTES       = 2048;
    localparam int NAME_STORE_BYTES = 2048;
    localparam int LINE_POS_W       = $clog2(LINE_BYTES);
    localparam int NAME_OFF_W       = $clog2(NAME_STORE_BYTES);
    localparam int TOKEN_POS_W      = 11;
    localparam int VALUE_W          = 31;
    localparam int BYTE_W           = 8;
    localparam int KW_BUF_DEPTH     = 4;
    localparam int KW_IDX_W         = $clog2(KW_BUF_DEPTH);
    localparam int KW_CNT_W         = 3;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_LOW_T = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_F = 8'h66;

    typedef enum logic [3:0] {
        TK_PLUS      = 4'd0,
        TK_MINUS     = 4'd1,
        TK_MUL       = 4'd2,
        TK_DIV       = 4'd3,
        TK_NUMBER    = 4'd4,
        TK_BOOL      = 4'd5,
        TK_IDENT     = 4'd6,
        TK_NAME_BYTE = 4'd7,
        TK_ERROR     = 4'd8
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUMBER  = 3'd1,
        MODE_KEYWORD = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_ERROR   = 3'd4
    } scan_mode_t;

    typedef logic [KW_BUF_DEPTH-1:0][BYTE_W-1:0] kw_buf_t;

    typedef struct packed {
        logic                     head_en;
        token_kind_t              head_kind;
        logic [VALUE_W-1:0]       head_value;
        logic [TOKEN_POS_W-1:0]   head_pos;
        logic [KW_CNT_W-1:0]      buf_cnt;
        kw_buf_t                  buf_bytes;
        logic [TOKEN_POS_W-1:0]   buf_base;
        logic                     name_en;
        logic [BYTE_W-1:0]        name_byte;
        logic                     tail_en;
        token_kind_t              tail_kind;
        logic [TOKEN_POS_W-1:0]   pos;
    } exl_desc_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input logic is_false,
                                                 input logic [KW_CNT_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        ch = CH_NUL;
        if (is_false) begin
            case (idx)
                3'd0:    ch = 8'h66;
                3'd1:    ch = 8'h61;
                3'd2:    ch = 8'h6C;
                3'd3:    ch = 8'h73;
                3'd4:    ch = 8'h65;
                default: ch = CH_NUL;
            endcase
        end else begin
            case (idx)
                3'd0:    ch = 8'h74;
                3'd1:    ch = 8'h72;
                3'd2:    ch = 8'h75;
                3'd3:    ch = 8'h65;
                default: ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ src/exl_front.sv @@
`default_nettype none

module exl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          text_byte,
    input  logic                text_valid,
    output logic                text_ready,
    output logic                push_valid,
    input  logic                push_ready,
    output exl_pkg::exl_desc_t  push_data
);
    import exl_pkg::*;

    scan_mode_t              mode_reg, mode_next;
    logic [VALUE_W-1:0]      acc_reg, acc_next;
    kw_buf_t                 kbuf_reg, kbuf_next;
    logic [KW_CNT_W-1:0]     kcount_reg, kcount_next;
    logic                    kfalse_reg, kfalse_next;
    logic [LINE_POS_W-1:0]   line_pos_reg, line_pos_next;
    logic [LINE_POS_W-1:0]   tstart_reg, tstart_next;
    logic [NAME_OFF_W-1:0]   noff_reg, noff_next;

    logic                    accept;
    logic                    c_digit, c_letter, c_alnum, c_op, c_kw_start;
    logic [BYTE_W-1:0]       c_lower;
    token_kind_t             op_kind;
    logic [KW_CNT_W-1:0]     kw_last, kw_idx;
    logic                    kw_match, kw_done;
    logic [VALUE_W+3:0]      acc_x10;
    logic [VALUE_W-1:0]      acc_sat;
    logic [TOKEN_POS_W-1:0]  pos_tok, tstart_tok;
    logic [NAME_OFF_W:0]     noff_sum;
    exl_desc_t               d;

    assign accept     = text_valid && push_ready;
    assign text_ready = push_ready;

    assign c_digit    = is_digit(text_byte);
    assign c_letter   = is_letter(text_byte);
    assign c_alnum    = c_digit || c_letter;
    assign c_lower    = to_lower(text_byte);
    assign c_kw_start = (c_lower == CH_LOW_T) || (c_lower == CH_LOW_F);

    always_comb
    begin
        c_op    = 1'b1;
        op_kind = TK_PLUS;
        case (text_byte)
            CH_PLUS:  op_kind = TK_PLUS;
            CH_MINUS: op_kind = TK_MINUS;
            CH_STAR:  op_kind = TK_MUL;
            CH_SLASH: op_kind = TK_DIV;
            default:  c_op = 1'b0;
        endcase
    end

    assign kw_last  = kfalse_reg ? 3'd4 : 3'd3;
    assign kw_idx   = (kcount_reg > kw_last || kcount_reg >= 3'd4) ? kw_last : kcount_reg;
    assign kw_match = (c_lower == kw_char(kfalse_reg, kw_idx));
    assign kw_done  = kw_match && (kw_idx == kw_last);

    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + (VALUE_W+4)'(text_byte[3:0]);
    assign acc_sat = (acc_x10 > (VALUE_W+4)'(NUM_MAX)) ? NUM_MAX : acc_x10[VALUE_W-1:0];

    assign pos_tok    = TOKEN_POS_W'(line_pos_reg);
    assign tstart_tok = TOKEN_POS_W'(tstart_reg);

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            case (mode_reg)
                MODE_NUMBER:
                    if (!c_digit)
                        mode_next = c_letter ? MODE_ERROR : MODE_IDLE;
                MODE_KEYWORD:
                    if (kw_match)
                    begin
                        if (kw_done)
                            mode_next = MODE_IDLE;
                    end
                    else
                        mode_next = c_alnum ? MODE_IDENT : MODE_IDLE;
                MODE_IDENT:
                    if (!c_alnum)
                        mode_next = MODE_IDLE;
                MODE_ERROR:
                    mode_next = MODE_ERROR;
                default:
                    if (c_digit)
                        mode_next = MODE_NUMBER;
                    else if (c_letter)
                        mode_next = c_kw_start ? MODE_KEYWORD : MODE_IDENT;
                    else
                        mode_next = MODE_IDLE;
            endcase
            if (text_byte == CH_NUL)
                mode_next = MODE_IDLE;
        end
    end

    always_comb
    begin
        d             = '0;
        d.pos         = pos_tok;
        d.buf_base    = tstart_tok;
        d.buf_bytes   = kbuf_reg;
        acc_next      = acc_reg;
        kbuf_next     = kbuf_reg;
        kcount_next   = kcount_reg;
        kfalse_next   = kfalse_reg;
        tstart_next   = tstart_reg;
        line_pos_next = line_pos_reg;
        noff_sum      = '0;
        noff_next     = noff_reg;
        if (accept)
        begin
            case (mode_reg)
                MODE_NUMBER:
                    if (c_digit)
                        acc_next = acc_sat;
                    else
                    begin
                        d.head_en    = 1'b1;
                        d.head_kind  = TK_NUMBER;
                        d.head_value = acc_reg;
                        d.head_pos   = tstart_tok;
                        d.tail_en    = c_letter || c_op;
                        d.tail_kind  = c_letter ? TK_ERROR : op_kind;
                    end
                MODE_KEYWORD:
                    if (kw_match)
                    begin
                        if (kw_done)
                        begin
                            d.head_en    = 1'b1;
                            d.head_kind  = TK_BOOL;
                            d.head_value = VALUE_W'(!kfalse_reg);
                            d.head_pos   = tstart_tok;
                            kcount_next  = '0;
                        end
                        else
                        begin
                            kbuf_next[kw_idx[KW_IDX_W-1:0]] = text_byte;
                            kcount_next = kw_idx + 3'd1;
                        end
                    end
                    else
                    begin
                        d.head_en    = 1'b1;
                        d.head_kind  = TK_IDENT;
                        d.head_value = VALUE_W'(noff_reg);
                        d.head_pos   = tstart_tok;
                        d.buf_cnt    = kw_idx;
                        d.name_en    = 1'b1;
                        d.name_byte  = c_alnum ? text_byte : CH_NUL;
                        d.tail_en    = !c_alnum && c_op;
                        d.tail_kind  = op_kind;
                        kcount_next  = '0;
                    end
                MODE_IDENT:
                begin
                    d.name_en   = 1'b1;
                    d.name_byte = c_alnum ? text_byte : CH_NUL;
                    d.tail_en   = !c_alnum && c_op;
                    d.tail_kind = op_kind;
                end
                MODE_ERROR:
                    d.tail_en = 1'b0;
                default:
                    if (c_digit)
                    begin
                        acc_next    = VALUE_W'(text_byte[3:0]);
                        tstart_next = line_pos_reg;
                    end
                    else if (c_letter)
                    begin
                        tstart_next = line_pos_reg;
                        if (c_kw_start)
                        begin
                            kbuf_next[0] = text_byte;
                            kcount_next  = 3'd1;
                            kfalse_next  = (c_lower == CH_LOW_F);
                        end
                        else
                        begin
                            d.head_en    = 1'b1;
                            d.head_kind  = TK_IDENT;
                            d.head_value = VALUE_W'(noff_reg);
                            d.head_pos   = pos_tok;
                            d.name_en    = 1'b1;
                            d.name_byte  = text_byte;
                        end
                    end
                    else
                    begin
                        d.tail_en   = c_op;
                        d.tail_kind = op_kind;
                    end
            endcase

            noff_sum = {1'b0, noff_reg} + (NAME_OFF_W+1)'(d.buf_cnt)
                     + (NAME_OFF_W+1)'(d.name_en);
            if (noff_sum >= (NAME_OFF_W+1)'(NAME_STORE_BYTES))
                noff_next = NAME_OFF_W'(noff_sum - (NAME_OFF_W+1)'(NAME_STORE_BYTES));
            else
                noff_next = noff_sum[NAME_OFF_W-1:0];

            if (text_byte == CH_NUL)
            begin
                kcount_next   = '0;
                line_pos_next = '0;
            end
            else if (line_pos_reg < LINE_POS_W'(LINE_BYTES - 1))
                line_pos_next = line_pos_reg + 1'b1;
        end
    end

    assign push_data  = d;
    assign push_valid = accept && (d.head_en || d.name_en || d.tail_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            acc_reg      <= '0;
            kbuf_reg     <= '0;
            kcount_reg   <= '0;
            kfalse_reg   <= 1'b0;
            line_pos_reg <= '0;
            tstart_reg   <= '0;
            noff_reg     <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            kbuf_reg     <= kbuf_next;
            kcount_reg   <= kcount_next;
            kfalse_reg   <= kfalse_next;
            line_pos_reg <= line_pos_next;
            tstart_reg   <= tstart_next;
            noff_reg     <= noff_next;
        end
    end

endmodule

`default_nettype wire

@@ src/exl_queue.sv @@
`default_nettype none

module exl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  exl_pkg::exl_desc_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output exl_pkg::exl_desc_t  pop_data
);
    import exl_pkg::*;

    exl_desc_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop_ready |-> pop_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ src/exl_back.sv @@
`default_nettype none

module exl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                desc_valid,
    output logic                desc_ready,
    input  exl_pkg::exl_desc_t  desc,
    output logic                token_valid,
    input  logic                token_ready,
    output logic [3:0]          token_kind,
    output logic [30:0]         token_value,
    output logic [10:0]         token_position,
    output logic                last_of_run
);
    import exl_pkg::*;

    logic                    head_done_reg, head_done_next;
    logic [KW_CNT_W-1:0]     buf_idx_reg, buf_idx_next;
    logic                    name_done_reg, name_done_next;
    logic                    tail_done_reg, tail_done_next;

    logic                    out_valid_reg;
    token_kind_t             out_kind_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic [TOKEN_POS_W-1:0]  out_pos_reg;
    logic                    out_last_reg;

    token_kind_t             sel_kind;
    logic [VALUE_W-1:0]      sel_value;
    logic [TOKEN_POS_W-1:0]  sel_pos;
    logic                    sel_last;
    logic                    out_free, step;

    assign out_free = !out_valid_reg || token_ready;
    assign step     = desc_valid && out_free;

    always_comb
    begin
        sel_kind       = desc.tail_kind;
        sel_value      = '0;
        sel_pos        = desc.pos;
        head_done_next = head_done_reg;
        buf_idx_next   = buf_idx_reg;
        name_done_next = name_done_reg;
        tail_done_next = tail_done_reg;
        if (desc.head_en && !head_done_reg)
        begin
            sel_kind       = desc.head_kind;
            sel_value      = desc.head_value;
            sel_pos        = desc.head_pos;
            head_done_next = 1'b1;
        end
        else if (buf_idx_reg < desc.buf_cnt)
        begin
            sel_kind     = TK_NAME_BYTE;
            sel_value    = VALUE_W'(desc.buf_bytes[buf_idx_reg[KW_IDX_W-1:0]]);
            sel_pos      = desc.buf_base + TOKEN_POS_W'(buf_idx_reg);
            buf_idx_next = buf_idx_reg + 1'b1;
        end
        else if (desc.name_en && !name_done_reg)
        begin
            sel_kind       = TK_NAME_BYTE;
            sel_value      = VALUE_W'(desc.name_byte);
            name_done_next = 1'b1;
        end
        else
            tail_done_next = 1'b1;

        sel_last = !((desc.head_en && !head_done_next) || (buf_idx_next < desc.buf_cnt)
                  || (desc.name_en && !name_done_next) || (desc.tail_en && !tail_done_next));
    end

    assign desc_ready = step && sel_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_done_reg <= 1'b0;
            buf_idx_reg   <= '0;
            name_done_reg <= 1'b0;
            tail_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                if (sel_last)
                begin
                    head_done_reg <= 1'b0;
                    buf_idx_reg   <= '0;
                    name_done_reg <= 1'b0;
                    tail_done_reg <= 1'b0;
                end
                else
                begin
                    head_done_reg <= head_done_next;
                    buf_idx_reg   <= buf_idx_next;
                    name_done_reg <= name_done_next;
                    tail_done_reg <= tail_done_next;
                end
            end
            if (step)
                out_valid_reg <= 1'b1;
            else if (token_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_kind_reg  <= sel_kind;
            out_value_reg <= sel_value;
            out_pos_reg   <= sel_pos;
            out_last_reg  <= sel_last;
        end
    end

    assign token_valid    = out_valid_reg;
    assign token_kind     = out_kind_reg;
    assign token_value    = out_value_reg;
    assign token_position = out_pos_reg;
    assign last_of_run    = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        buf_idx_reg <= KW_CNT_W'(KW_BUF_DEPTH))
        else $error("name byte index past keyword buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (head_done_reg || name_done_reg || tail_done_reg || buf_idx_reg != '0) |-> desc_valid)
        else $error("expansion progress without a pending word");

endmodule

`default_nettype wire

@@ src/expression_lexer_core.sv @@
// Channel   Valid        Ready        Payload
// text      text_valid   text_ready   text_byte
// token     token_valid  token_ready  token_kind, token_value, token_position, last_of_run
//
// One text byte is taken per cycle while the descriptor queue has room.
// A byte can yield up to 7 tokens, which leave the output stage one token word per
// cycle while token_ready is high; the queue (4 entries) absorbs the bursts.
// Reset clears the scanner state, the line position, the name offset and the queue.
// A stalled token port backs up the queue and then drops text_ready.
`default_nettype none

module expression_lexer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  text_byte,
    input  logic        text_valid,
    output logic        text_ready,
    output logic [3:0]  token_kind,
    output logic [30:0] token_value,
    output logic [10:0] token_position,
    output logic        last_of_run,
    output logic        token_valid,
    input  logic        token_ready
);
    import exl_pkg::*;

    logic       push_valid, push_ready;
    exl_desc_t  push_data;
    logic       pop_valid, pop_ready;
    exl_desc_t  pop_data;

    exl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (text_byte),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    exl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    exl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .desc_valid     (pop_valid),
        .desc_ready     (pop_ready),
        .desc           (pop_data),
        .token_valid    (token_valid),
        .token_ready    (token_ready),
        .token_kind     (token_kind),
        .token_value    (token_value),
        .token_position (token_position),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire

@@ tb/expression_lexer_core_tb.sv @@
`timescale 1ns / 100ps

module expression_lexer_core_tb;

    import exl_pkg::*;

    typedef struct packed {
        token_kind_t            kind;
        logic [VALUE_W-1:0]     value;
        logic [TOKEN_POS_W-1:0] pos;
        logic                   last;
    } token_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [BYTE_W-1:0]      text_byte;
    logic                   text_valid;
    logic                   text_ready;
    logic [3:0]             token_kind;
    logic [VALUE_W-1:0]     token_value;
    logic [TOKEN_POS_W-1:0] token_position;
    logic                   last_of_run;
    logic                   token_valid;
    logic                   token_ready;

    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned ready_hold     = 0;
    bit          steady         = 1'b0;

    scan_mode_t             lx_mode;
    logic [VALUE_W-1:0]     lx_acc;
    logic [BYTE_W-1:0]      lx_kw [KW_BUF_DEPTH];
    int unsigned            lx_kw_cnt;
    logic                   lx_kw_false;
    logic [TOKEN_POS_W-1:0] lx_line_pos;
    logic [TOKEN_POS_W-1:0] lx_start;
    logic [TOKEN_POS_W-1:0] lx_name_off;

    token_word_t token_burst[$];
    token_word_t pending_tokens[$];

    expression_lexer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_byte      (text_byte),
        .text_valid     (text_valid),
        .text_ready     (text_ready),
        .token_kind     (token_kind),
        .token_value    (token_value),
        .token_position (token_position),
        .last_of_run    (last_of_run),
        .token_valid    (token_valid),
        .token_ready    (token_ready)
    );

    always #5 clk = ~clk;

    function automatic bit digit_byte(logic [BYTE_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit letter_byte(logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(logic [BYTE_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] keyword_letter(logic is_false, int unsigned idx);
        string w;
        if (is_false)
        begin
            w = "false";
        end
        else
        begin
            w = "true";
        end
        return w[idx];
    endfunction

    function automatic void lexer_clear();
        lx_mode     = MODE_IDLE;
        lx_acc      = '0;
        lx_kw_cnt   = 0;
        lx_kw_false = 1'b0;
        lx_line_pos = '0;
        lx_start    = '0;
        lx_name_off = '0;
        foreach (lx_kw[k])
        begin
            lx_kw[k] = '0;
        end
    endfunction

    function automatic void push_token(token_kind_t k, logic [VALUE_W-1:0] v,
                                       logic [TOKEN_POS_W-1:0] p);
        token_word_t w;
        w.kind  = k;
        w.value = v;
        w.pos   = p;
        w.last  = 1'b0;
        if (token_burst.size() < 8)
        begin
            token_burst.push_back(w);
        end
    endfunction

    function automatic void push_name(logic [BYTE_W-1:0] c, logic [TOKEN_POS_W-1:0] p);
        push_token(TK_NAME_BYTE, VALUE_W'(c), p);
        if (int'(lx_name_off) + 1 >= NAME_STORE_BYTES)
        begin
            lx_name_off = '0;
        end
        else
        begin
            lx_name_off = lx_name_off + 1'b1;
        end
    endfunction

    function automatic void fresh_byte(logic [BYTE_W-1:0] c, logic [TOKEN_POS_W-1:0] p);
        lx_mode = MODE_IDLE;
        if (digit_byte(c))
        begin
            lx_mode  = MODE_NUMBER;
            lx_acc   = VALUE_W'(c - 8'h30);
            lx_start = p;
        end
        else if (letter_byte(c))
        begin
            lx_start = p;
            if (fold_case(c) == CH_LOW_T || fold_case(c) == CH_LOW_F)
            begin
                lx_mode     = MODE_KEYWORD;
                lx_kw[0]    = c;
                lx_kw_cnt   = 1;
                lx_kw_false = fold_case(c) == CH_LOW_F;
            end
            else
            begin
                lx_mode = MODE_IDENT;
                push_token(TK_IDENT, VALUE_W'(lx_name_off), p);
                push_name(c, p);
            end
        end
        else if (c == CH_PLUS)
        begin
            push_token(TK_PLUS, '0, p);
        end
        else if (c == CH_MINUS)
        begin
            push_token(TK_MINUS, '0, p);
        end
        else if (c == CH_STAR)
        begin
            push_token(TK_MUL, '0, p);
        end
        else if (c == CH_SLASH)
        begin
            push_token(TK_DIV, '0, p);
        end
    endfunction

    function automatic void lex_byte(logic [BYTE_W-1:0] c);
        logic [TOKEN_POS_W-1:0] p;
        int unsigned            len;
        int unsigned            idx;
        logic [63:0]            grown;
        token_word_t            w;
        p = lx_line_pos;
        case (lx_mode)
            MODE_ERROR:
            begin
            end
            MODE_NUMBER:
            begin
                if (digit_byte(c))
                begin
                    grown  = 64'(lx_acc) * 64'd10 + 64'(c - 8'h30);
                    lx_acc = (grown > 64'(NUM_MAX)) ? NUM_MAX : grown[VALUE_W-1:0];
                end
                else
                begin
                    push_token(TK_NUMBER, lx_acc, lx_start);
                    if (letter_byte(c))
                    begin
                        push_token(TK_ERROR, '0, p);
                        lx_mode = MODE_ERROR;
                    end
                    else
                    begin
                        fresh_byte(c, p);
                    end
                end
            end
            MODE_KEYWORD:
            begin
                len = lx_kw_false ? 5 : 4;
                idx = lx_kw_cnt;
                if (idx >= len || idx >= KW_BUF_DEPTH)
                begin
                    idx = len - 1;
                end
                if (fold_case(c) == keyword_letter(lx_kw_false, idx))
                begin
                    if (idx == len - 1)
                    begin
                        push_token(TK_BOOL, lx_kw_false ? '0 : VALUE_W'(1), lx_start);
                        lx_mode   = MODE_IDLE;
                        lx_kw_cnt = 0;
                    end
                    else
                    begin
                        lx_kw[idx] = c;
                        lx_kw_cnt  = idx + 1;
                    end
                end
                else
                begin
                    push_token(TK_IDENT, VALUE_W'(lx_name_off), lx_start);
                    for (int k = 0; k < idx; k++)
                    begin
                        push_name(lx_kw[k], lx_start + TOKEN_POS_W'(k));
                    end
                    lx_kw_cnt = 0;
                    if (letter_byte(c) || digit_byte(c))
                    begin
                        push_name(c, p);
                        lx_mode = MODE_IDENT;
                    end
                    else
                    begin
                        push_name(CH_NUL, p);
                        fresh_byte(c, p);
                    end
                end
            end
            MODE_IDENT:
            begin
                if (letter_byte(c) || digit_byte(c))
                begin
                    push_name(c, p);
                end
                else
                begin
                    push_name(CH_NUL, p);
                    fresh_byte(c, p);
                end
            end
            default:
            begin
                fresh_byte(c, p);
            end
        endcase

        if (c == CH_NUL)
        begin
            lx_mode     = MODE_IDLE;
            lx_line_pos = '0;
            lx_kw_cnt   = 0;
        end
        else if (int'(lx_line_pos) < LINE_BYTES - 1)
        begin
            lx_line_pos = lx_line_pos + 1'b1;
        end

        while (token_burst.size() > 0)
        begin
            w = token_burst.pop_front();
            if (token_burst.size() == 0)
            begin
                w.last = 1'b1;
            end
            pending_tokens.push_back(w);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_letter();
        int unsigned r;
        r = $urandom_range(0, 51);
        if (r < 26)
        begin
            return 8'h41 + BYTE_W'(r);
        end
        return 8'h61 + BYTE_W'(r - 26);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_alnum();
        if ($urandom_range(0, 3) == 0)
        begin
            return 8'h30 + BYTE_W'($urandom_range(0, 9));
        end
        return rand_letter();
    endfunction

    function automatic logic [BYTE_W-1:0] mix_case(logic [BYTE_W-1:0] c);
        if ($urandom_range(0, 1) != 0)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // hold the word until accepted; drop valid only when a gap follows
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_byte  <= b;
        text_valid <= 1'b1;
        @(posedge clk);
        while (!text_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            send_byte(s[k]);
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if (steady)
        begin
            token_ready <= 1'b1;
        end
        else
        begin
            token_ready <= $urandom_range(0, 2) != 0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        token_word_t got;
        token_word_t want;
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                lex_byte(text_byte);
            end
            if (token_valid && token_ready)
            begin
                got.kind  = token_kind_t'(token_kind);
                got.value = token_value;
                got.pos   = token_position;
                got.last  = last_of_run;
                if (pending_tokens.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: token word with none expected: kind %0d value %0d pos %0d last %0b",
                             $time, got.kind, got.value, got.pos, got.last);
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: expected kind %0d value %0d pos %0d last %0b, actual kind %0d value %0d pos %0d last %0b",
                                 $time, want.kind, want.value, want.pos, want.last,
                                 got.kind, got.value, got.pos, got.last);
                    end
                end
            end
        end
    end

    task automatic test_operators();
        send_text("+-*/");
        send_byte(8'hFF);
        send_byte(CH_NUL);
    endtask

    task automatic test_numbers();
        send_text("9999999999*0x");
        send_byte(8'h9C);
        send_byte(CH_NUL);
    endtask

    task automatic test_keywords();
        send_text("TrUeFALSEfals+t1");
        send_byte(CH_NUL);
    endtask

    task automatic test_long_line();
        steady = 1'b1;
        send_byte("q");
        for (int k = 0; k < 40; k++)
        begin
            send_byte((k % 2 == 0) ? "Z" : "7");
        end
        send_text(" +");
        send_byte(CH_NUL);
        send_byte("m");
        send_byte(CH_NUL);
        steady = 1'b0;
    endtask

    task automatic test_random_text();
        int unsigned       start_count;
        int unsigned       choice;
        int unsigned       n;
        logic [BYTE_W-1:0] ch;
        string             kw;
        start_count = bytes_sent;
        while (bytes_sent - start_count < 360)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                steady = ~steady;
            end
            if ($urandom_range(0, 1) != 0)
            begin
                kw = "true";
            end
            else
            begin
                kw = "false";
            end
            choice = $urandom_range(0, 19);
            if (choice < 3)
            begin
                case ($urandom_range(0, 3))
                    0:       ch = CH_PLUS;
                    1:       ch = CH_MINUS;
                    2:       ch = CH_STAR;
                    default: ch = CH_SLASH;
                endcase
                send_byte(ch);
            end
            else if (choice < 6)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
                repeat (n) send_byte(8'h30 + BYTE_W'($urandom_range(0, 9)));
            end
            else if (choice < 9)
            begin
                for (int k = 0; k < kw.len(); k++)
                begin
                    send_byte(mix_case(kw[k]));
                end
            end
            else if (choice < 11)
            begin
                n = $urandom_range(1, kw.len() - 1);
                for (int k = 0; k < n; k++)
                begin
                    send_byte(mix_case(kw[k]));
                end
                case ($urandom_range(0, 4))
                    0:       send_byte(rand_letter());
                    1:       send_byte(8'h30 + BYTE_W'($urandom_range(0, 9)));
                    2:       send_byte(CH_NUL);
                    3:       send_byte(CH_PLUS);
                    default: send_byte(BYTE_W'($urandom_range(1, 255)));
                endcase
            end
            else if (choice < 14)
            begin
                send_byte(rand_letter());
                repeat ($urandom_range(0, 6)) send_byte(rand_alnum());
            end
            else if (choice < 15)
            begin
                send_byte(8'h30 + BYTE_W'($urandom_range(0, 9)));
                send_byte(rand_letter());
                repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(1, 255)));
            end
            else if (choice < 17)
            begin
                send_byte(BYTE_W'($urandom_range(1, 255)));
            end
            else if (choice < 18)
            begin
                send_byte(CH_NUL);
            end
            if ($urandom_range(0, 1) != 0)
            begin
                send_byte(8'h20);
            end
        end
        send_byte(CH_NUL);
        steady = 1'b0;
    endtask

    initial
    begin
        int unsigned waited;
        rst_n       <= 1'b0;
        text_valid  <= 1'b0;
        text_byte   <= '0;
        token_ready <= 1'b0;
        lexer_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_operators();
        test_numbers();
        test_keywords();
        test_long_line();
        test_random_text();
        text_valid <= 1'b0;

        waited = 0;
        while (pending_tokens.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_tokens.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: expected %0d more token words, actual 0",
                     $time, pending_tokens.size());
        end
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("expression_lexer_core_tb OK");
        end
        else
        begin
            $display("expression_lexer_core_tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("expression_lexer_core_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
src/exl_pkg.sv
src/exl_front.sv
src/exl_queue.sv
src/exl_back.sv
src/expression_lexer_core.sv
tb/expression_lexer_core_tb.sv
